### hw/rtl/ccr_pkg.sv
`timescale 1ns / 1ps

package ccr_pkg;

  localparam int GRID_SIDE = 512;
  localparam int GRID_BITS = $clog2(GRID_SIDE);
  localparam int ADDR_BITS = 2 * GRID_BITS;
  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int COUNT_W = $clog2(GRID_SIDE + 1);
  localparam int BIT_W = (GRID_BITS > 1) ? $clog2(GRID_BITS) : 1;
  // cols * cell and the remainder of a coordinate divide
  localparam int LIM_W = COUNT_W + 21;
  // grid-relative sample coordinate, signed
  localparam int OFS_W = (LIM_W + 1 > 35) ? LIM_W + 1 : 35;

  localparam logic [2:0] CFG_CELL_SIZE = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_X = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd2;
  localparam logic [2:0] CFG_COLUMNS = 3'd3;
  localparam logic [2:0] CFG_ROWS = 3'd4;
  localparam logic [2:0] CFG_RADIUS = 3'd5;
  localparam logic [2:0] CFG_ROBOT_WIDTH = 3'd6;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [7:0] LETHAL_COST = 8'd254;
  localparam logic [20:0] CELL_MIN = 21'd64;
  localparam logic [20:0] CELL_MAX = 21'd1048576;
  localparam logic [20:0] RADIUS_MAX = 21'd1048576;
  localparam logic [31:0] RECIP_FIVE = 32'((64'd1 << 32) / 64'd5);
  localparam logic [8:0] FIVE = 9'd5;

  typedef struct packed {
    logic [20:0]        cell_size;
    logic signed [31:0] grid_origin_x;
    logic signed [31:0] grid_origin_y;
    logic [9:0]         grid_columns;
    logic [9:0]         grid_rows;
    logic [20:0]        search_radius;
    logic [18:0]        body_width;
  } cfg_t;

  typedef struct packed {
    logic               mode;
    logic [8:0]         cell_column;
    logic [8:0]         cell_row;
    logic [7:0]         cell_cost;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [15:0]        heading;
  } req_t;

  typedef struct packed {
    logic [21:0] left_clr;
    logic [21:0] right_clr;
    logic [22:0] corridor_width;
    logic        narrow_flag;
    logic        door_flag;
  } rsp_t;

  // taylor term n+1 divides by (2n+2)(2n+3)
  function automatic logic [8:0] term_div(input logic [2:0] n);
    logic [8:0] r;
    case (n)
      3'd0: r = 9'd6;
      3'd1: r = 9'd20;
      3'd2: r = 9'd42;
      3'd3: r = 9'd72;
      3'd4: r = 9'd110;
      3'd5: r = 9'd156;
      3'd6: r = 9'd210;
      default: r = 9'd272;
    endcase
    return r;
  endfunction

  // floor(2^32 / term_div)
  function automatic logic [31:0] term_recip(input logic [2:0] n);
    logic [31:0] r;
    case (n)
      3'd0: r = 32'((64'd1 << 32) / 64'd6);
      3'd1: r = 32'((64'd1 << 32) / 64'd20);
      3'd2: r = 32'((64'd1 << 32) / 64'd42);
      3'd3: r = 32'((64'd1 << 32) / 64'd72);
      3'd4: r = 32'((64'd1 << 32) / 64'd110);
      3'd5: r = 32'((64'd1 << 32) / 64'd156);
      3'd6: r = 32'((64'd1 << 32) / 64'd210);
      default: r = 32'((64'd1 << 32) / 64'd272);
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/ccr_ram.sv
`timescale 1ns / 1ps

module ccr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/ccr_mul.sv
`timescale 1ns / 1ps

module ccr_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= 64'(a) * 64'(b);
  end

endmodule

### hw/rtl/ccr_core.sv
`timescale 1ns / 1ps

module ccr_core (
  input  logic                          clk,
  input  logic                          rst,
  input  ccr_pkg::cfg_t                 cfg,
  input  logic                          start,
  input  ccr_pkg::req_t                 req,
  output logic                          busy,
  output logic                          res_valid,
  input  logic                          res_ready,
  output ccr_pkg::rsp_t                 res,
  output logic [ccr_pkg::ADDR_BITS-1:0] rd_addr,
  input  logic [7:0]                    rd_data
);

  import ccr_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_SIN_X   = 5'd1;
  localparam logic [4:0] S_SIN_X2  = 5'd2;
  localparam logic [4:0] S_SIN_T   = 5'd3;
  localparam logic [4:0] S_SIN_P   = 5'd4;
  localparam logic [4:0] S_SIN_Q   = 5'd5;
  localparam logic [4:0] S_SIN_C   = 5'd6;
  localparam logic [4:0] S_SIN_F   = 5'd7;
  localparam logic [4:0] S_SETUP_A = 5'd8;
  localparam logic [4:0] S_SETUP_B = 5'd9;
  localparam logic [4:0] S_SETUP_C = 5'd10;
  localparam logic [4:0] S_SETUP_D = 5'd11;
  localparam logic [4:0] S_SETUP_E = 5'd12;
  localparam logic [4:0] S_RAY_M1  = 5'd13;
  localparam logic [4:0] S_RAY_M2  = 5'd14;
  localparam logic [4:0] S_RAY_M3  = 5'd15;
  localparam logic [4:0] S_RAY_DIV = 5'd16;
  localparam logic [4:0] S_RAY_RD  = 5'd17;
  localparam logic [4:0] S_RAY_CHK = 5'd18;
  localparam logic [4:0] S_DONE    = 5'd19;

  logic [4:0] state;

  logic signed [31:0] px, py;
  logic [15:0] head;
  logic which;

  logic [31:0] x2, t, p, qe;
  logic signed [33:0] s;
  logic [2:0] n;

  logic [16:0] sn_mag, cs_mag;
  logic sn_neg, cs_neg;

  logic [21:0] stride;
  logic [LIM_W-1:0] xlim, ylim;
  logic signed [OFS_W-1:0] pdx, pdy, ox;
  logic side;
  logic [21:0] d;
  logic [21:0] left, right;
  logic [LIM_W-1:0] remx, remy;
  logic [GRID_BITS-1:0] cx, cy;
  logic [BIT_W-1:0] bit_i;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  ccr_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // effective configuration
  logic [20:0] cell_eff, radius_eff;
  logic [21:0] limit;
  logic [COUNT_W-1:0] cols_eff, rows_eff;
  logic [22:0] v5;

  always_comb begin
    if (cfg.cell_size < CELL_MIN) cell_eff = CELL_MIN;
    else if (cfg.cell_size > CELL_MAX) cell_eff = CELL_MAX;
    else cell_eff = cfg.cell_size;
    radius_eff = (cfg.search_radius > RADIUS_MAX) ? RADIUS_MAX : cfg.search_radius;
    cols_eff = (32'(cfg.grid_columns) > GRID_SIDE) ? COUNT_W'(GRID_SIDE)
                                                   : COUNT_W'(cfg.grid_columns);
    rows_eff = (32'(cfg.grid_rows) > GRID_SIDE) ? COUNT_W'(GRID_SIDE)
                                                : COUNT_W'(cfg.grid_rows);
  end

  assign limit = {radius_eff, 1'b0};
  assign v5 = {cell_eff, 2'b10};

  // angle of the sine being formed, folded to the first quarter
  logic [15:0] angle;
  logic [14:0] kk;
  assign angle = which ? (head + 16'd16384) : head;
  assign kk = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};

  logic [30:0] x_w;
  logic [31:0] hi30, hi32;
  logic [31:0] rem_t, tn;
  logic [33:0] sc;
  logic [16:0] vq;
  logic [22:0] rx_u, ry_u;
  logic signed [OFS_W-1:0] rx_s, ry_s, ox_w, oy_w;
  logic off_map;
  logic [LIM_W-1:0] sh_cell;
  logic [31:0] rem5;
  logic stop;
  logic [21:0] stop_dist;

  assign x_w = 31'((prod + 64'd16384) >> 15);
  assign hi30 = prod[61:30];
  assign hi32 = prod[63:32];
  assign rem_t = p - prod[31:0];
  assign tn = (rem_t >= 32'(term_div(n))) ? qe + 32'd1 : qe;
  assign sc = (s < 0) ? 34'd0 : 34'(s);
  assign vq = 17'((sc + 34'd8192) >> 14);
  assign rem5 = 32'(v5) - prod[31:0];

  assign rx_u = 23'((prod + 64'd32768) >> 16);
  assign ry_u = rx_u;
  assign rx_s = OFS_W'(rx_u);
  assign ry_s = OFS_W'(ry_u);
  // left ray runs along (-sin, cos), right along (sin, -cos)
  assign ox_w = (side ? sn_neg : !sn_neg) ? pdx - rx_s : pdx + rx_s;
  assign oy_w = (side ? !cs_neg : cs_neg) ? pdy - ry_s : pdy + ry_s;
  assign off_map = (ox < 0) || (oy_w < 0) || (ox >= $signed(OFS_W'(xlim)))
                   || (oy_w >= $signed(OFS_W'(ylim)));
  assign sh_cell = LIM_W'(cell_eff) << bit_i;

  always_comb begin
    stop = 1'b0;
    stop_dist = d;
    case (state)
      S_RAY_M1: begin
        if (d >= limit) begin
          stop = 1'b1;
          stop_dist = limit;
        end
      end
      S_RAY_M3: stop = off_map;
      S_RAY_CHK: stop = (rd_data >= LETHAL_COST);
      default: stop = 1'b0;
    endcase
  end

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      S_SIN_X: begin
        mul_a = 32'(kk);
        mul_b = PI_Q30;
      end
      S_SIN_X2: begin
        mul_a = 32'(x_w);
        mul_b = 32'(x_w);
      end
      S_SIN_T: begin
        mul_a = t;
        mul_b = hi30;
      end
      S_SIN_P: begin
        mul_a = hi30;
        mul_b = term_recip(n);
      end
      S_SIN_Q: begin
        mul_a = hi32;
        mul_b = 32'(term_div(n));
      end
      S_SIN_C: begin
        mul_a = tn;
        mul_b = x2;
      end
      S_SETUP_A: begin
        mul_a = 32'(v5);
        mul_b = RECIP_FIVE;
      end
      S_SETUP_B: begin
        mul_a = hi32;
        mul_b = 32'(FIVE);
      end
      S_SETUP_C: begin
        mul_a = 32'(cols_eff);
        mul_b = 32'(cell_eff);
      end
      S_SETUP_D: begin
        mul_a = 32'(rows_eff);
        mul_b = 32'(cell_eff);
      end
      S_RAY_M1: begin
        mul_a = 32'(sn_mag);
        mul_b = 32'(d);
      end
      S_RAY_M2: begin
        mul_a = 32'(cs_mag);
        mul_b = 32'(d);
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      side <= 1'b0;
      d <= 22'd0;
      left <= 22'd0;
      which <= 1'b0;
    end else if (stop) begin
      if (!side) begin
        left <= stop_dist;
        side <= 1'b1;
        d <= 22'd0;
        state <= S_RAY_M1;
      end else begin
        right <= stop_dist;
        d <= stop_dist;
        state <= S_DONE;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            px <= req.point_x;
            py <= req.point_y;
            head <= req.heading;
            which <= 1'b0;
            state <= S_SIN_X;
          end
        end
        S_SIN_X: state <= S_SIN_X2;
        S_SIN_X2: begin
          t <= 32'(x_w);
          s <= 34'(x_w);
          state <= S_SIN_T;
        end
        S_SIN_T: begin
          x2 <= hi30;
          n <= 3'd0;
          state <= S_SIN_P;
        end
        S_SIN_P: begin
          p <= hi30;
          state <= S_SIN_Q;
        end
        S_SIN_Q: begin
          qe <= hi32;
          state <= S_SIN_C;
        end
        S_SIN_C: begin
          t <= tn;
          // odd terms subtract
          s <= n[0] ? s + $signed({2'b00, tn}) : s - $signed({2'b00, tn});
          if (n == 3'd7) begin
            state <= S_SIN_F;
          end else begin
            n <= n + 3'd1;
            state <= S_SIN_P;
          end
        end
        S_SIN_F: begin
          if (!which) begin
            sn_mag <= vq;
            sn_neg <= angle[15];
            which <= 1'b1;
            state <= S_SIN_X;
          end else begin
            cs_mag <= vq;
            cs_neg <= angle[15];
            state <= S_SETUP_A;
          end
        end
        S_SETUP_A: begin
          pdx <= OFS_W'(px) - OFS_W'(cfg.grid_origin_x);
          pdy <= OFS_W'(py) - OFS_W'(cfg.grid_origin_y);
          state <= S_SETUP_B;
        end
        S_SETUP_B: begin
          qe <= hi32;
          state <= S_SETUP_C;
        end
        S_SETUP_C: begin
          stride <= 22'((rem5 >= 32'(FIVE)) ? qe + 32'd1 : qe);
          state <= S_SETUP_D;
        end
        S_SETUP_D: begin
          xlim <= LIM_W'(prod);
          state <= S_SETUP_E;
        end
        S_SETUP_E: begin
          ylim <= LIM_W'(prod);
          side <= 1'b0;
          d <= 22'd0;
          state <= S_RAY_M1;
        end
        S_RAY_M1: state <= S_RAY_M2;
        S_RAY_M2: begin
          ox <= ox_w;
          state <= S_RAY_M3;
        end
        S_RAY_M3: begin
          remx <= LIM_W'(ox);
          remy <= LIM_W'(oy_w);
          cx <= '0;
          cy <= '0;
          bit_i <= BIT_W'(GRID_BITS - 1);
          state <= S_RAY_DIV;
        end
        S_RAY_DIV: begin
          // one quotient bit of each coordinate per cycle
          if (remx >= sh_cell) begin
            remx <= remx - sh_cell;
            cx[bit_i] <= 1'b1;
          end
          if (remy >= sh_cell) begin
            remy <= remy - sh_cell;
            cy[bit_i] <= 1'b1;
          end
          if (bit_i == '0) begin
            state <= S_RAY_RD;
          end else begin
            bit_i <= bit_i - BIT_W'(1);
          end
        end
        S_RAY_RD: state <= S_RAY_CHK;
        S_RAY_CHK: begin
          d <= d + stride;
          state <= S_RAY_M1;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic [22:0] sum;
  logic [26:0] w10, rw18, rw13;

  assign sum = {1'b0, left} + {1'b0, right};
  assign w10 = (27'(sum) << 3) + (27'(sum) << 1);
  assign rw18 = (27'(cfg.body_width) << 4) + (27'(cfg.body_width) << 1);
  assign rw13 = (27'(cfg.body_width) << 3) + (27'(cfg.body_width) << 2)
                + 27'(cfg.body_width);

  assign busy = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.left_clr = left;
  assign res.right_clr = right;
  assign res.corridor_width = sum;
  assign res.narrow_flag = (w10 < rw18);
  assign res.door_flag = (w10 < rw13);
  assign rd_addr = {cy, cx};

endmodule

### hw/rtl/corridor_clearance_raycaster_unit.sv
`timescale 1ns / 1ps

// corridor clearance ray marcher over a loaded cost grid
// request channel (req_valid / req_stall / req): mode write stores one grid
// cell and produces no response; mode query takes a point
// and heading and produces one response on rsp_valid / rsp_stall / rsp.
// a query first forms sine and cosine with the shared multiplier, then runs
// the setup steps, then marches the left and the right ray. every ray sample
// takes two scale multiplies, a one bit per cycle cell divide and one grid
// memory read. a ray ends when it reaches its limit or leaves the map.
// req_stall is high for the whole query; writes and queries are taken only
// while the marcher is idle. the response sits in an output register; while
// rsp_stall holds it, the marcher waits with the next result and accepts no
// new request. configuration is written through cfg_wr_en / cfg_index /
// cfg_data; the user must do so only while the block is idle; the block
// does not enforce it. rst restores the default register values. grid cells
// hold no value until written and must be written before a ray reads them.

module corridor_clearance_raycaster_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ccr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ccr_pkg::rsp_t rsp,
  input  logic          cfg_wr_en,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  import ccr_pkg::*;

  cfg_t cfg;
  logic busy, res_valid, res_ready;
  rsp_t res;
  logic [ADDR_BITS-1:0] rd_addr, wr_addr;
  logic [7:0] rd_data;
  logic req_take, wr_en, start;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_size <= 21'd3277;
      cfg.grid_origin_x <= 32'sd0;
      cfg.grid_origin_y <= 32'sd0;
      cfg.grid_columns <= 10'd512;
      cfg.grid_rows <= 10'd512;
      cfg.search_radius <= 21'd65536;
      cfg.body_width <= 19'd32768;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CELL_SIZE: cfg.cell_size <= cfg_data[20:0];
        CFG_ORIGIN_X: cfg.grid_origin_x <= cfg_data;
        CFG_ORIGIN_Y: cfg.grid_origin_y <= cfg_data;
        CFG_COLUMNS: cfg.grid_columns <= cfg_data[9:0];
        CFG_ROWS: cfg.grid_rows <= cfg_data[9:0];
        CFG_RADIUS: cfg.search_radius <= cfg_data[20:0];
        CFG_ROBOT_WIDTH: cfg.body_width <= cfg_data[18:0];
        default: ;
      endcase
    end
  end

  assign req_stall = busy;
  assign req_take = req_valid && !req_stall;
  assign start = req_take && (req.mode == MODE_QUERY);
  assign wr_en = req_take && (req.mode == MODE_WRITE)
                 && (32'(req.cell_column) < GRID_SIDE) && (32'(req.cell_row) < GRID_SIDE);
  assign wr_addr = {GRID_BITS'(req.cell_row), GRID_BITS'(req.cell_column)};

  ccr_ram #(
    .WIDTH (8),
    .DEPTH (GRID_CELLS)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req.cell_cost),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ccr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (start),
    .req       (req),
    .busy      (busy),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req.mode == MODE_QUERY) |=> req_stall)
    else $error("query accepted but marcher not busy");

  a_width_sum: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.corridor_width
                   == 23'(rsp.left_clr) + 23'(rsp.right_clr)))
    else $error("corridor width is not the sum of clearances");

  a_door_narrow: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.door_flag) |-> rsp.narrow_flag)
    else $error("doorway flagged without narrow");

endmodule
